// File: sv/pcss_pkg.sv
// Shared widths, register indexes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none

package pcss_pkg;

	localparam int GAIN_W  = 24;
	localparam int LIM_DW  = 16;
	localparam int MAG_W   = 15;
	localparam int ERR_W   = 17;
	localparam int EMAG_W  = 16;
	localparam int CHG_W   = 17;
	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int DNUM_W  = 41;
	localparam int DDEN_W  = 16;
	localparam int RNUM_W  = 20;
	localparam int CNT_W   = 4;
	localparam int DRV_W   = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

	localparam logic [2:0] REG_GAIN_PROP  = 3'd0;
	localparam logic [2:0] REG_GAIN_INTEG = 3'd1;
	localparam logic [2:0] REG_GAIN_DERIV = 3'd2;
	localparam logic [2:0] REG_LIMIT_LOW  = 3'd3;
	localparam logic [2:0] REG_LIMIT_HIGH = 3'd4;
	localparam logic [2:0] REG_MIN_MAG    = 3'd5;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_prop;
		logic signed [GAIN_W-1:0] gain_integ;
		logic signed [GAIN_W-1:0] gain_deriv;
		logic signed [LIM_DW-1:0] limit_low;
		logic signed [LIM_DW-1:0] limit_high;
		logic [MAG_W-1:0]         min_magnitude;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic restart;
		logic mul_p;
		logic mul_i;
		logic mul_d;
		logic div_d;
		logic clamp_d;
		logic sum;
		logic whole;
		logic ramp_mul;
		logic div_r;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic err_zero;
		logic ramp_active;
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

// File: sv/pcss_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pcss_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [pcss_pkg::DNUM_W-1:0] num,
	input  wire logic [pcss_pkg::DDEN_W-1:0] den,
	output logic                            busy,
	output logic [pcss_pkg::DNUM_W-1:0]      quot
);
	import pcss_pkg::*;

	localparam int IT_W = $clog2(DNUM_W + 1);

	logic              run_q;
	logic [IT_W-1:0]   iter_q;
	logic [DDEN_W-1:0] rem_q;
	logic [DDEN_W-1:0] den_q;
	logic [DNUM_W-1:0] quo_q;
	logic [DDEN_W:0]   trial;
	logic [DDEN_W:0]   diff;
	logic              fits;

	assign trial = {rem_q, quo_q[DNUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			iter_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			iter_q <= IT_W'(DNUM_W);
		end else if (run_q) begin
			iter_q <= iter_q - 1'b1;
			if (iter_q == IT_W'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= fits ? diff[DDEN_W-1:0] : trial[DDEN_W-1:0];
			quo_q <= {quo_q[DNUM_W-2:0], fits};
		end
	end

	assign busy = run_q;
	assign quot = quo_q;

	a_no_restart_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q)
		else $error("divider started while a division is in progress");

endmodule

`default_nettype wire

// File: sv/pcss_ctrl.sv
// Sequencer that steps the datapath through one control step or a restart.
`timescale 1ns / 1ps
`default_nettype none

module pcss_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_kind,
	input  wire pcss_pkg::sts_t sts,
	output pcss_pkg::cmd_t      cmd,
	output logic                in_ready
);
	import pcss_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RESTART,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_DIV_D,
		ST_WAIT_D,
		ST_CLAMP_D,
		ST_SUM,
		ST_WHOLE,
		ST_RAMP_MUL,
		ST_DIV_R,
		ST_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= in_kind ? ST_RESTART : ST_MUL_P;
					end
				end
				ST_RESTART:  state_q <= ST_IDLE;
				ST_MUL_P:    state_q <= ST_MUL_I;
				ST_MUL_I:    state_q <= ST_MUL_D;
				ST_MUL_D:    state_q <= ST_DIV_D;
				ST_DIV_D:    state_q <= sts.err_zero ? ST_CLAMP_D : ST_WAIT_D;
				ST_WAIT_D: begin
					if (!sts.div_busy) begin
						state_q <= ST_CLAMP_D;
					end
				end
				ST_CLAMP_D:  state_q <= ST_SUM;
				ST_SUM:      state_q <= ST_WHOLE;
				ST_WHOLE:    state_q <= sts.ramp_active ? ST_RAMP_MUL : ST_FINISH;
				ST_RAMP_MUL: state_q <= ST_DIV_R;
				ST_DIV_R:    state_q <= ST_FINISH;
				ST_FINISH: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:     cmd.load     = in_valid;
			ST_RESTART:  cmd.restart  = 1'b1;
			ST_MUL_P:    cmd.mul_p    = 1'b1;
			ST_MUL_I:    cmd.mul_i    = 1'b1;
			ST_MUL_D:    cmd.mul_d    = 1'b1;
			ST_DIV_D:    cmd.div_d    = !sts.err_zero;
			ST_CLAMP_D:  cmd.clamp_d  = 1'b1;
			ST_SUM:      cmd.sum      = 1'b1;
			ST_WHOLE:    cmd.whole    = 1'b1;
			ST_RAMP_MUL: cmd.ramp_mul = 1'b1;
			ST_DIV_R:    cmd.div_r    = 1'b1;
			ST_FINISH:   cmd.emit     = !sts.out_busy;
			default:     cmd = '0;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	a_idle_divider_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !sts.div_busy)
		else $error("divider still running while the controller is idle");

endmodule

`default_nettype wire

// File: sv/pcss_dp.sv
// Datapath: PID state, shared multiplier, clamps, soft-start scaling and output word.
`timescale 1ns / 1ps
`default_nettype none

module pcss_dp #(
	parameter int FRAC_BITS  = 8,
	parameter int RAMP_STEPS = 10
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire pcss_pkg::cfg_t                    cfg,
	input  wire pcss_pkg::cmd_t                    cmd,
	input  wire logic signed [pcss_pkg::LIM_DW-1:0] target,
	input  wire logic signed [pcss_pkg::LIM_DW-1:0] measured,
	input  wire logic                              out_ready,
	output pcss_pkg::sts_t                         sts,
	output logic                                   out_valid,
	output logic [pcss_pkg::DRV_W-1:0]             drive
);
	import pcss_pkg::*;

	localparam int LIM_W = LIM_DW + FRAC_BITS;
	localparam int EXT_W = ((PROD_W > LIM_W) ? PROD_W : LIM_W) + 2;
	localparam int DX_W  = DRV_W + 1;
	localparam logic [LIM_W:0] FRAC_MASK = (LIM_W + 1)'((64'd1 << FRAC_BITS) - 64'd1);

	// Division by RAMP_STEPS is a multiply by its rounded-up reciprocal, exact for every
	// ramp numerator below 2**RNUM_W while RAMP_STEPS stays at or below 16.
	localparam int RECIP_SH = RNUM_W + 4;
	localparam int RP_W     = RNUM_W + RECIP_SH + 1;
	localparam logic [RECIP_SH:0] RECIP = (RECIP_SH + 1)'(
		((64'd1 << RECIP_SH) + 64'(RAMP_STEPS) - 64'd1) / 64'(RAMP_STEPS));

	// Upper limit tested first: crossed limits give hi for v > hi, lo otherwise.
	function automatic logic signed [LIM_W-1:0] clamp_lim(
		input logic signed [EXT_W-1:0] v,
		input logic signed [EXT_W-1:0] lo,
		input logic signed [EXT_W-1:0] hi
	);
		logic signed [EXT_W-1:0] r;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r[LIM_W-1:0];
	endfunction

	logic signed [ERR_W-1:0]  err_q;
	logic signed [ERR_W-1:0]  last_err_q;
	logic [CHG_W-1:0]         chg_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] p_q;
	logic signed [LIM_W-1:0]  integ_q;
	logic signed [LIM_W-1:0]  deriv_q;
	logic signed [LIM_W-1:0]  sum_q;
	logic signed [DRV_W-1:0]  whole_q;
	logic [RNUM_W-1:0]        rprod_q;
	logic [RNUM_W-1:0]        rquot_q;
	logic [CNT_W-1:0]         count_q;
	logic [DRV_W-1:0]         out_q;
	logic                     out_valid_q;

	logic signed [EXT_W-1:0]   lo_ext;
	logic signed [EXT_W-1:0]   hi_ext;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_y;
	logic [GAIN_W-1:0]         gd_mag;
	logic [EMAG_W-1:0]         err_mag;
	logic signed [MUL_B_W-1:0] err_diff;
	logic                      neg_d;
	logic signed [EXT_W-1:0]   q_ext;
	logic signed [EXT_W-1:0]   d_sel;
	logic signed [LIM_W:0]     sum_b;
	logic signed [LIM_W:0]     sum_sh;
	logic [DRV_W-1:0]          whole_mag;
	logic [RP_W-1:0]           rmul;
	logic signed [DX_W-1:0]    rq_x;
	logic signed [DX_W-1:0]    d_ext;
	logic signed [DX_W-1:0]    mm;
	logic signed [DX_W-1:0]    drv_fin;
	logic                      div_start;
	logic [DNUM_W-1:0]         div_num;
	logic [DDEN_W-1:0]         div_den;
	logic                      div_busy;
	logic [DNUM_W-1:0]         div_quot;

	assign lo_ext = EXT_W'(cfg.limit_low) <<< FRAC_BITS;
	assign hi_ext = EXT_W'(cfg.limit_high) <<< FRAC_BITS;

	assign gd_mag   = cfg.gain_deriv[GAIN_W-1] ? GAIN_W'(-cfg.gain_deriv) : cfg.gain_deriv;
	assign err_mag  = err_q[ERR_W-1] ? EMAG_W'(-err_q) : err_q[EMAG_W-1:0];
	assign err_diff = MUL_B_W'(err_q) - MUL_B_W'(last_err_q);

	// One shared multiplier; the product is always registered before use.
	always_comb begin
		mul_a = MUL_A_W'(cfg.gain_prop);
		mul_b = MUL_B_W'(err_q);
		if (cmd.mul_i) begin
			mul_a = MUL_A_W'(cfg.gain_integ);
		end else if (cmd.mul_d) begin
			mul_a = $signed({1'b0, gd_mag});
			mul_b = $signed({1'b0, chg_q});
		end
	end
	assign mul_y = mul_a * mul_b;

	// The derivative quotient is negative when -gain_deriv and the error differ in sign.
	assign neg_d = !cfg.gain_deriv[GAIN_W-1] ^ err_q[ERR_W-1];
	assign q_ext = $signed(EXT_W'(div_quot));
	assign d_sel = (err_q == '0) ? EXT_W'(deriv_q) : (neg_d ? -q_ext : q_ext);

	// Truncation toward zero: bias negative values before the arithmetic shift.
	assign sum_b  = $signed((LIM_W + 1)'(sum_q) + (sum_q[LIM_W-1] ? FRAC_MASK : '0));
	assign sum_sh = sum_b >>> FRAC_BITS;

	assign whole_mag = whole_q[DRV_W-1] ? DRV_W'(-whole_q) : whole_q;

	assign rmul = RP_W'(rprod_q) * RP_W'(RECIP);

	assign rq_x    = $signed(DX_W'(rquot_q));
	assign d_ext   = sts.ramp_active ? (whole_q[DRV_W-1] ? -rq_x : rq_x) : DX_W'(whole_q);
	assign mm      = $signed({{(DX_W-MAG_W){1'b0}}, cfg.min_magnitude});
	assign drv_fin = (!d_ext[DX_W-1] && d_ext < mm) ? mm :
	                 ((d_ext[DX_W-1] && d_ext > -mm) ? -mm : d_ext);

	assign div_start = cmd.div_d;
	assign div_num   = prod_q[DNUM_W-1:0];
	assign div_den   = err_mag;

	pcss_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.num        (div_num),
		.den        (div_den),
		.busy       (div_busy),
		.quot       (div_quot)
	);

	// Controller state that persists across words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			deriv_q     <= '0;
			last_err_q  <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				last_err_q <= '0;
				count_q    <= CNT_W'(1);
			end
			if (cmd.mul_i) begin
				last_err_q <= err_q;
				if (count_q != CNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.mul_d) begin
				integ_q <= clamp_lim(EXT_W'(integ_q) + EXT_W'(prod_q), lo_ext, hi_ext);
			end
			if (cmd.clamp_d) begin
				deriv_q <= clamp_lim(d_sel, lo_ext, hi_ext);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers for one step.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q <= ERR_W'(target) - ERR_W'(measured);
		end
		if (cmd.mul_p) begin
			chg_q <= err_diff[MUL_B_W-1] ? CHG_W'(-err_diff) : CHG_W'(err_diff);
		end
		if (cmd.mul_p || cmd.mul_i || cmd.mul_d) begin
			prod_q <= mul_y;
		end
		if (cmd.mul_i) begin
			p_q <= prod_q;
		end
		if (cmd.sum) begin
			sum_q <= clamp_lim(EXT_W'(p_q) + EXT_W'(integ_q) + EXT_W'(deriv_q),
				lo_ext, hi_ext);
		end
		if (cmd.whole) begin
			whole_q <= sum_sh[DRV_W-1:0];
		end
		if (cmd.ramp_mul) begin
			rprod_q <= RNUM_W'(whole_mag) * RNUM_W'(count_q);
		end
		if (cmd.div_r) begin
			rquot_q <= rmul[RECIP_SH +: RNUM_W];
		end
		if (cmd.emit) begin
			out_q <= drv_fin[DRV_W-1:0];
		end
	end

	assign sts.div_busy    = div_busy;
	assign sts.err_zero    = (err_q == '0);
	assign sts.ramp_active = (count_q < CNT_W'(RAMP_STEPS));
	assign sts.out_busy    = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign drive     = out_q;

	a_restart_sets_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.restart |=> (count_q == CNT_W'(1)))
		else $error("restart did not set the run count to one");

	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result written over a word not yet taken");

endmodule

`default_nettype wire

// File: sv/pid_controller_soft_start_core.sv
// Top level: register port, controller, datapath and stream ports of the PID core.
//
//  Port group        Dir  Width  Contents
//  s_tdata/s_tuser   in   32/1   target [15:0], measured [31:16]; tuser = kind
//  m_tdata           out  16     drive [15:0]
//  psel..prdata      cfg  32     APB registers at byte address 4*index
//
//  A run word is dominated by the serial derivative divide (41 quotient bits) and adds
//  a ramp multiply and divide while the soft-start ramp is active.
//  A restart word resets the error history and ramp count. A zero error skips the divide.
//  A finished result waits in the output register; the next word is accepted meanwhile
//  and stalls only at its final step while that register is still full.
//  Reset clears the controller state and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_soft_start_core #(
	parameter int FRAC_BITS  = 8,
	parameter int RAMP_STEPS = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // target [15:0], measured [31:16]
	input  wire logic        s_tuser,  // kind [0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata   // drive [15:0]
);
	import pcss_pkg::*;

	cfg_t       cfg_q;
	cmd_t       cmd;
	sts_t       sts;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop     <= '0;
			cfg_q.gain_integ    <= '0;
			cfg_q.gain_deriv    <= '0;
			cfg_q.limit_low     <= 16'sh8000;
			cfg_q.limit_high    <= 16'sh7fff;
			cfg_q.min_magnitude <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_GAIN_PROP:  cfg_q.gain_prop     <= pwdata[GAIN_W-1:0];
				REG_GAIN_INTEG: cfg_q.gain_integ    <= pwdata[GAIN_W-1:0];
				REG_GAIN_DERIV: cfg_q.gain_deriv    <= pwdata[GAIN_W-1:0];
				REG_LIMIT_LOW:  cfg_q.limit_low     <= pwdata[LIM_DW-1:0];
				REG_LIMIT_HIGH: cfg_q.limit_high    <= pwdata[LIM_DW-1:0];
				REG_MIN_MAG:    cfg_q.min_magnitude <= pwdata[MAG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GAIN_PROP:  prdata = 32'(cfg_q.gain_prop);
			REG_GAIN_INTEG: prdata = 32'(cfg_q.gain_integ);
			REG_GAIN_DERIV: prdata = 32'(cfg_q.gain_deriv);
			REG_LIMIT_LOW:  prdata = 32'(cfg_q.limit_low);
			REG_LIMIT_HIGH: prdata = 32'(cfg_q.limit_high);
			REG_MIN_MAG:    prdata = {17'd0, cfg_q.min_magnitude};
			default:        prdata = '0;
		endcase
	end

	pcss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (s_tready)
	);

	pcss_dp #(
		.FRAC_BITS  (FRAC_BITS),
		.RAMP_STEPS (RAMP_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.target    ($signed(s_tdata[15:0])),
		.measured  ($signed(s_tdata[31:16])),
		.out_ready (m_tready),
		.sts       (sts),
		.out_valid (m_tvalid),
		.drive     (m_tdata)
	);

endmodule

`default_nettype wire

// File: verif/pid_controller_soft_start_core_test.sv
// Self-checking stream testbench for the soft-start PID controller core.
`timescale 1ns / 1ps

module pid_controller_soft_start_core_test;

	import pcss_pkg::*;

	localparam int FRAC_BITS    = 8;
	localparam int RAMP_STEPS   = 10;
	localparam longint SCALE    = longint'(1) << FRAC_BITS;
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES   = 400;
	localparam int TIMEOUT_NS    = 4_000_000;

	// Register slots beyond the last defined one; writes there must change nothing.
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	typedef enum logic {
		KIND_RUN     = 1'b0,
		KIND_RESTART = 1'b1
	} kind_e;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	wire  [31:0] prdata;
	wire         pready;
	logic        s_tvalid;
	wire         s_tready;
	logic [31:0] s_tdata;  // target [15:0], measured [31:16]
	logic        s_tuser;  // kind [0]
	wire         m_tvalid;
	logic        m_tready;
	wire  [15:0] m_tdata;  // drive [15:0]

	// Controller copy kept by the testbench.
	cfg_t   cfg_m;
	longint i_term   = 0;
	longint d_term   = 0;
	longint prev_err = 0;
	longint ramp_cnt = 0;

	logic [15:0] drive_q[$];
	logic [15:0] want;

	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int rx_gap = 0;

	int n_errors   = 0;
	int n_runs     = 0;
	int n_restarts = 0;
	int n_results  = 0;
	int n_settings = 0;

	pid_controller_soft_start_core #(
		.FRAC_BITS (FRAC_BITS),
		.RAMP_STEPS(RAMP_STEPS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= 40)
			$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// Advances the controller copy by one word and queues the drive it produces.
	task automatic predict_word(input kind_e kind, input logic signed [15:0] tgt,
			input logic signed [15:0] meas);
		longint err, chg, lo, hi, sum, whole, drv, mag;
		if (kind == KIND_RESTART) begin
			prev_err = 0;
			ramp_cnt = 1;
			return;
		end
		err = longint'(tgt) - longint'(meas);
		lo = longint'($signed(cfg_m.limit_low)) * SCALE;
		hi = longint'($signed(cfg_m.limit_high)) * SCALE;
		i_term = clip(i_term + longint'($signed(cfg_m.gain_integ)) * err, lo, hi);
		chg = err - prev_err;
		if (chg < 0)
			chg = -chg;
		// The derivative is held over a zero error but still clamped to the current limits.
		if (err != 0)
			d_term = (-longint'($signed(cfg_m.gain_deriv)) * chg) / err;
		d_term = clip(d_term, lo, hi);
		sum = clip(longint'($signed(cfg_m.gain_prop)) * err + i_term + d_term, lo, hi);
		whole = sum / SCALE;
		prev_err = err;
		if (ramp_cnt < 15)
			ramp_cnt++;
		drv = (ramp_cnt < RAMP_STEPS) ? (whole * ramp_cnt) / RAMP_STEPS : whole;
		mag = longint'(cfg_m.min_magnitude);
		if (drv >= 0 && drv < mag)
			drv = mag;
		else if (drv < 0 && drv > -mag)
			drv = -mag;
		drive_q.push_back(drv[15:0]);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_GAIN_PROP:  cfg_m.gain_prop = value[23:0];
			REG_GAIN_INTEG: cfg_m.gain_integ = value[23:0];
			REG_GAIN_DERIV: cfg_m.gain_deriv = value[23:0];
			REG_LIMIT_LOW:  cfg_m.limit_low = value[15:0];
			REG_LIMIT_HIGH: cfg_m.limit_high = value[15:0];
			REG_MIN_MAG:    cfg_m.min_magnitude = value[14:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] gp, input logic [31:0] gi,
			input logic [31:0] gd, input logic [31:0] lo, input logic [31:0] hi,
			input logic [31:0] mm);
		write_reg(REG_GAIN_PROP, gp);
		write_reg(REG_GAIN_INTEG, gi);
		write_reg(REG_GAIN_DERIV, gd);
		write_reg(REG_LIMIT_LOW, lo);
		write_reg(REG_LIMIT_HIGH, hi);
		write_reg(REG_MIN_MAG, mm);
		n_settings++;
	endtask

	// Offers one word, with an occasional idle burst first, and returns once it is taken.
	task automatic send_word(input kind_e kind, input logic signed [15:0] tgt,
			input logic signed [15:0] meas);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
		predict_word(kind, tgt, meas);
		if (kind == KIND_RESTART)
			n_restarts++;
		else
			n_runs++;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {meas, tgt};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Waits until every queued drive has arrived and the core has had time to go quiet.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (drive_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic send_random_run();
		logic signed [15:0] tgt, meas;
		tgt = 16'($urandom);
		case ($urandom_range(0, 7))
			0, 1, 2: meas = 16'($urandom);
			3: meas = tgt;
			4: begin
				tgt = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				meas = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			end
			default: meas = tgt + 16'($urandom_range(0, 400)) - 16'sd200;
		endcase
		send_word(KIND_RUN, tgt, meas);
	endtask

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 6))
			0: return 32'd0;
			1: return {8'($urandom), 24'h800000};
			2: return {8'($urandom), 24'h7FFFFF};
			3: return $urandom;
			default: return 32'($signed($urandom_range(0, 1023)) - 512);
		endcase
	endfunction

	task automatic pick_config();
		logic [15:0] lo, hi;
		logic [31:0] mm;
		case ($urandom_range(0, 3))
			0: begin
				lo = 16'h8000;
				hi = 16'h7FFF;
			end
			1: begin
				lo = 16'($urandom);
				hi = 16'($urandom);
				if ($signed(lo) > $signed(hi)) begin
					lo = lo ^ hi;
					hi = lo ^ hi;
					lo = lo ^ hi;
				end
			end
			// Either order, so crossed limits come up now and then.
			2: begin
				lo = 16'($urandom);
				hi = 16'($urandom);
			end
			default: begin
				lo = 16'(-$signed($urandom_range(0, 2000)));
				hi = 16'($urandom_range(0, 2000));
			end
		endcase
		case ($urandom_range(0, 5))
			0, 1: mm = {17'($urandom), 15'd0};
			2: mm = {17'($urandom), 15'($urandom_range(1, 200))};
			3: mm = $urandom;
			4: mm = {17'($urandom), 15'h7FFF};
			default: mm = 32'd0;
		endcase
		set_config(rand_gain(), rand_gain(), rand_gain(), {16'($urandom), lo},
			{16'($urandom), hi}, mm);
	endtask

	task automatic test_reset_defaults();
		// All gains are zero after reset, so the drive is zero whatever the error.
		send_word(KIND_RUN, 16'sh7FFF, 16'sh8000);
		send_word(KIND_RUN, 16'sh8000, 16'sh7FFF);
	endtask

	task automatic test_basic_steps();
		wait_idle();
		set_config(32'd256, 32'd16, 32'd64, 32'hFFFF_8000, 32'h0000_7FFF, 32'd0);
		send_word(KIND_RESTART, 16'sd0, 16'sd0);
		send_word(KIND_RUN, 16'sd1000, 16'sd0);
		send_word(KIND_RUN, 16'sd1000, 16'sd1000);
		send_word(KIND_RUN, 16'sh7FFF, 16'sh8000);
		send_word(KIND_RUN, 16'sh8000, 16'sh7FFF);
		send_word(KIND_RUN, 16'sd0, 16'sd0);
		send_word(KIND_RESTART, 16'sh7FFF, 16'sh8000);
		send_word(KIND_RUN, -16'sd500, 16'sd100);
		send_word(KIND_RUN, 16'sd100, 16'sd100);
	endtask

	task automatic test_crossed_limits();
		wait_idle();
		set_config(32'd256, 32'd0, 32'd0, 32'd100, 32'hFFFF_FF9C, 32'd0);
		send_word(KIND_RESTART, 16'sd0, 16'sd0);
		send_word(KIND_RUN, 16'sd10, 16'sd0);
		send_word(KIND_RUN, 16'sd1000, 16'sd0);
		send_word(KIND_RUN, -16'sd1000, 16'sd0);
		send_word(KIND_RUN, 16'sd0, 16'sd0);
	endtask

	task automatic test_min_magnitude();
		wait_idle();
		set_config(32'd1, 32'd0, 32'd0, 32'hFFFF_8000, 32'h0000_7FFF, 32'd300);
		send_word(KIND_RUN, 16'sd5, 16'sd5);
		send_word(KIND_RUN, -16'sd40, 16'sd0);
		send_word(KIND_RUN, 16'sd40, 16'sd0);
		wait_idle();
		write_reg(REG_MIN_MAG, 32'hFFFF_FFFF);
		send_word(KIND_RUN, 16'sd0, 16'sd0);
		send_word(KIND_RUN, -16'sd300, 16'sd0);
	endtask

	task automatic test_spare_registers();
		wait_idle();
		set_config(32'h007F_FFFF, 32'h0080_0000, 32'h007F_FFFF, 32'hFFFF_8000,
			32'h0000_7FFF, 32'd0);
		write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_B, 32'h1234_5678);
		send_word(KIND_RESTART, 16'sd0, 16'sd0);
		send_word(KIND_RUN, 16'sd3, 16'sd0);
		send_word(KIND_RUN, -16'sd3, 16'sd0);
		send_word(KIND_RUN, 16'sd0, -16'sd1);
	endtask

	// Restart followed by a run of control steps is the usual shape; the rest is loose words.
	task automatic test_random_phases(input int phases, input int per_phase, input bit idle);
		int ph, sent, runs, k;
		for (ph = 0; ph < phases; ph++) begin
			wait_idle();
			pick_config();
			idle_on = idle && (ph % 4 != 3);
			sent = 0;
			while (sent < per_phase) begin
				if ($urandom_range(0, 9) < 8) begin
					send_word(KIND_RESTART, 16'($urandom), 16'($urandom));
					runs = $urandom_range(1, 20);
					for (k = 0; k < runs; k++)
						send_random_run();
					sent += runs + 1;
				end else begin
					if ($urandom_range(0, 1))
						send_word(KIND_RESTART, 16'($urandom), 16'($urandom));
					else
						send_random_run();
					sent++;
				end
			end
		end
		idle_on = 1'b1;
	endtask

	task automatic test_output_backpressure();
		int k;
		wait_idle();
		set_config(32'd256, 32'd32, 32'd64, 32'hFFFF_B1E0, 32'h0000_4E20, 32'd0);
		idle_on = 1'b0;
		hold_req <= 1'b1;
		send_word(KIND_RESTART, 16'sd0, 16'sd0);
		for (k = 0; k < 10; k++)
			send_word(KIND_RUN, 16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)));
		idle_on = 1'b1;
	endtask

	// Long receiver hold-off, started on request and counted down here.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Checks each drive word taken at this edge, then chooses the next ready level.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (drive_q.size() == 0) begin
				report_mismatch($sformatf("drive word %0d with nothing expected",
					$signed(m_tdata)));
			end else begin
				want = drive_q.pop_front();
				n_results++;
				if (m_tdata !== want)
					report_mismatch($sformatf("drive %0d, expected %0d",
						$signed(m_tdata), $signed(want)));
			end
		end
		if (!arst_n || hold_left != 0) begin
			m_tready <= 1'b0;
		end else if (rx_gap != 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			rx_gap = $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d drive words outstanding", drive_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_m.gain_prop = '0;
		cfg_m.gain_integ = '0;
		cfg_m.gain_deriv = '0;
		cfg_m.limit_low = 16'h8000;
		cfg_m.limit_high = 16'h7FFF;
		cfg_m.min_magnitude = '0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_basic_steps();
		test_crossed_limits();
		test_min_magnitude();
		test_spare_registers();
		test_random_phases(12, 140, 1'b1);
		test_output_backpressure();
		test_random_phases(1, 150, 1'b0);
		wait_idle();

		$display("Sent %0d run and %0d restart words over %0d register settings;",
			n_runs, n_restarts, n_settings);
		$display("checked %0d drive words, including one long output stall.", n_results);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sim.f
sv/pcss_pkg.sv
sv/pcss_div.sv
sv/pcss_ctrl.sv
sv/pcss_dp.sv
sv/pid_controller_soft_start_core.sv
verif/pid_controller_soft_start_core_test.sv
